/* sv/kskm_pkg.sv */
// ----------------------------------------------------------------------------
// Kaiser-Squires kernel multiplier package
// Shared widths, operation codes and the divider pipeline word.
// ----------------------------------------------------------------------------
package kskm_pkg;

  // Operation codes.
  localparam logic [1:0] OP_FWD  = 2'd0;
  localparam logic [1:0] OP_ADJ  = 2'd1;
  localparam logic [1:0] OP_INV  = 2'd2;
  localparam logic [1:0] OP_RSVD = 2'd3;

  // Dividend (magnitude plus half divisor), divisor and quotient widths.
  localparam int DW = 52;
  localparam int SDW = 17;
  localparam int QW = 34;

  // Word handed from one divider cell to the next.
  typedef struct packed {
    logic           vld;
    logic           zero;
    logic           neg_re;
    logic           neg_im;
    logic [SDW-1:0] den;
    logic [DW-1:0]  rem_re;
    logic [DW-1:0]  rem_im;
    logic [QW-1:0]  quo_re;
    logic [QW-1:0]  quo_im;
  } div_word_t;

endpackage

/* sv/kskm_div_cell.sv */
// ----------------------------------------------------------------------------
// Kaiser-Squires divider cell
// Resolves one quotient bit of both the real and imaginary division.
// ----------------------------------------------------------------------------
module kskm_div_cell import kskm_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  div_word_t word_i,
  output div_word_t word_o
);

  logic [DW-1:0] trial;
  div_word_t     word_d;
  div_word_t     word_q;

  // Divisor aligned to this cell's quotient bit.
  assign trial = DW'(word_i.den) << SHIFT;

  // Restoring step on both numerators.
  always_comb begin
    word_d = word_i;
    if (word_i.rem_re >= trial) begin
      word_d.rem_re        = word_i.rem_re - trial;
      word_d.quo_re[SHIFT] = 1'b1;
    end
    if (word_i.rem_im >= trial) begin
      word_d.rem_im        = word_i.rem_im - trial;
      word_d.quo_im[SHIFT] = 1'b1;
    end
  end

  // The whole word moves on when the pipeline advances.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;

endmodule

/* sv/kaiser_squires_kernel_multiply_top.sv */
// ----------------------------------------------------------------------------
// Kaiser-Squires kernel multiplier
// Multiplies a Fourier bin by the shear kernel D or its conjugate; code three gives zero.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one Fourier bin per beat (operation, row,
// col and a Q15.16 complex sample). The output channel returns one Q15.16
// complex result per beat, in input order. Both channels use valid/stall.
// The grid side is written through cfg_we_i/cfg_data_i while idle.
// An accepted input beat passes the registers for index mapping, frequency
// squares, kernel products and numerator sums, then a chain of 34 divider
// cells that each settle one quotient bit, then one output register. One
// beat is taken every cycle unless the pipeline holds, so new bins enter
// while earlier ones are still in the divider chain, one bin per clock.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle; bubbles are not squeezed out.
// Reset clears all valid bits and sets the grid side to 256.
// ----------------------------------------------------------------------------
module kaiser_squires_kernel_multiply_top import kskm_pkg::*; #(
  parameter int MAX_SIDE = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         col_i,
  input  logic signed [31:0] sample_re_i,
  input  logic signed [31:0] sample_im_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_re_o,
  output logic signed [31:0] result_im_o
);

  logic       adv;
  logic [8:0] side_q;
  logic [8:0] side_eff;

  // Pipeline advances unless a result is held by the receiver.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Grid side register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= 9'd256;
    end else if (cfg_we_i) begin
      side_q <= cfg_data_i;
    end
  end

  // Side in use is clamped to the legal range.
  always_comb begin
    side_eff = side_q;
    if (side_q < 9'd2) begin
      side_eff = 9'd2;
    end else if ({4'd0, side_q} > 13'(MAX_SIDE)) begin
      side_eff = 9'(MAX_SIDE);
    end
  end

  // Stage 1: map indices to signed frequencies.
  logic               s1_vld_q;
  logic [1:0]         s1_op_q;
  logic signed [9:0]  s1_kx_q, s1_ky_q;
  logic signed [31:0] s1_x_q, s1_y_q;
  logic signed [9:0]  kx_d, ky_d;

  always_comb begin
    kx_d = ({col_i, 1'b0} < ({1'b0, side_eff} + 10'd2))
         ? $signed({2'b00, col_i}) : $signed({2'b00, col_i}) - $signed({1'b0, side_eff});
    ky_d = ({row_i, 1'b0} < ({1'b0, side_eff} + 10'd2))
         ? $signed({2'b00, row_i}) : $signed({2'b00, row_i}) - $signed({1'b0, side_eff});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_op_q <= operation_i;
      s1_kx_q <= kx_d;
      s1_ky_q <= ky_d;
      s1_x_q  <= sample_re_i;
      s1_y_q  <= sample_im_i;
    end
  end

  // Stage 2: squares and cross product of the frequencies.
  logic               s2_vld_q;
  logic [1:0]         s2_op_q;
  logic signed [19:0] s2_kx2_q, s2_ky2_q, s2_kxy_q;
  logic signed [31:0] s2_x_q, s2_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_op_q  <= s1_op_q;
      s2_kx2_q <= s1_kx_q * s1_kx_q;
      s2_ky2_q <= s1_ky_q * s1_ky_q;
      s2_kxy_q <= s1_kx_q * s1_ky_q;
      s2_x_q   <= s1_x_q;
      s2_y_q   <= s1_y_q;
    end
  end

  // Stage 3: kernel terms and the four numerator products.
  logic               s3_vld_q;
  logic               s3_zero_q;
  logic [1:0]         s3_op_q;
  logic [SDW-1:0]     s3_den_q;
  logic signed [49:0] s3_xa_q, s3_yb_q, s3_xb_q, s3_ya_q;
  logic signed [19:0] a_d, b_d, s_d;

  always_comb begin
    a_d = s2_ky2_q - s2_kx2_q;
    b_d = s2_kxy_q <<< 1;
    s_d = s2_kx2_q + s2_ky2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  // Kernel terms fit in 18 signed bits; products stay signed.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_op_q   <= s2_op_q;
      s3_zero_q <= (s_d == 20'sd0) || (s2_op_q == OP_RSVD);
      s3_den_q  <= s_d[SDW-1:0];
      s3_xa_q   <= 50'(s2_x_q * $signed(a_d[17:0]));
      s3_yb_q   <= 50'(s2_y_q * $signed(b_d[17:0]));
      s3_xb_q   <= 50'(s2_x_q * $signed(b_d[17:0]));
      s3_ya_q   <= 50'(s2_y_q * $signed(a_d[17:0]));
    end
  end

  // Stage 4: numerators, signs and rounded dividend magnitudes.
  div_word_t          chain [QW+1];
  div_word_t          head_d;
  div_word_t          head_q;
  logic signed [50:0] nre_d, nim_d;
  logic [50:0]        mre_d, mim_d;

  always_comb begin
    if (s3_op_q == OP_FWD) begin
      nre_d = 51'(s3_xa_q) - 51'(s3_yb_q);
      nim_d = 51'(s3_xb_q) + 51'(s3_ya_q);
    end else begin
      nre_d = 51'(s3_xa_q) + 51'(s3_yb_q);
      nim_d = 51'(s3_ya_q) - 51'(s3_xb_q);
    end
    mre_d = nre_d[50] ? 51'(-nre_d) : 51'(nre_d);
    mim_d = nim_d[50] ? 51'(-nim_d) : 51'(nim_d);
  end

  always_comb begin
    head_d.vld    = s3_vld_q;
    head_d.zero   = s3_zero_q;
    head_d.neg_re = nre_d[50];
    head_d.neg_im = nim_d[50];
    head_d.den    = s3_den_q;
    head_d.rem_re = DW'(mre_d) + DW'(s3_den_q >> 1);
    head_d.rem_im = DW'(mim_d) + DW'(s3_den_q >> 1);
    head_d.quo_re = '0;
    head_d.quo_im = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (adv) begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  // Divider chain, most significant quotient bit first.
  for (genvar g = 0; g < QW; g++) begin : g_cell
    kskm_div_cell #(
      .SHIFT(QW - 1 - g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .word_i(chain[g]),
      .word_o(chain[g+1])
    );
  end

  // Saturate, apply sign and register the output beat.
  div_word_t   last;
  logic [31:0] rre_d, rim_d;

  assign last = chain[QW];

  always_comb begin
    if (last.neg_re) begin
      rre_d = (last.quo_re > QW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-last.quo_re);
    end else begin
      rre_d = (last.quo_re > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : last.quo_re[31:0];
    end
    if (last.neg_im) begin
      rim_d = (last.quo_im > QW'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-last.quo_im);
    end else begin
      rim_d = (last.quo_im > QW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : last.quo_im[31:0];
    end
    if (last.zero) begin
      rre_d = '0;
      rim_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      result_re_o <= rre_d;
      result_im_o <= rim_d;
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Kaiser-Squires kernel multiplier testbench
// Drives Fourier bins through the kernel multiplier with bursty input and a
// stalling receiver, predicts each product in 64-bit integer arithmetic and
// compares every output beat field by field in order.
// ----------------------------------------------------------------------------
module testbench import kskm_pkg::*;;

  // Expected product of one bin.
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } product_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [8:0]         cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [1:0]         operation_i = '0;
  logic [7:0]         row_i = '0;
  logic [7:0]         col_i = '0;
  logic signed [31:0] sample_re_i = '0;
  logic signed [31:0] sample_im_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] result_re_o;
  logic signed [31:0] result_im_o;

  localparam int LATENCY = 39;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_SIDE = 256;

  product_t   expected_products[$];
  logic [8:0] side_reg = 9'd256;
  int         error_count = 0;
  int         beats_sent = 0;
  int         beats_checked = 0;
  int         idle_cycles = 0;
  int         burst_left = 0;
  int         stall_mode = 0;

  kaiser_squires_kernel_multiply_top #(.MAX_SIDE(MAX_SIDE)) dut (.*);

  // Clock generation.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Signed frequency of a grid index.
  function automatic longint freq_of_index(logic [7:0] idx, longint side);
    longint k;
    k = longint'(idx);
    if (2 * k < side + 2) return k;
    return k - side;
  endfunction

  // Round to nearest with ties away from zero, then saturate to 32 bits.
  function automatic logic signed [31:0] round_saturate(longint num, longint den);
    logic [63:0] mag;
    logic [63:0] quo;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    quo = (mag + 64'(den / 2)) / 64'(den);
    if (num < 0) begin
      if (quo > 64'h8000_0000) quo = 64'h8000_0000;
      return 32'(-quo);
    end
    if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
    return 32'(quo);
  endfunction

  // Kernel product of one bin under the current grid side.
  function automatic product_t kernel_product(logic [1:0] op, logic [7:0] row,
                                              logic [7:0] col, logic signed [31:0] xr,
                                              logic signed [31:0] xi);
    product_t p;
    longint side, kx, ky, a, b, s, x, y, nre, nim;
    side = longint'(side_reg);
    if (side < 2) side = 2;
    if (side > MAX_SIDE) side = MAX_SIDE;
    ky = freq_of_index(row, side);
    kx = freq_of_index(col, side);
    x = longint'(xr);
    y = longint'(xi);
    s = kx * kx + ky * ky;
    p.re = '0;
    p.im = '0;
    if (s == 0 || op == OP_RSVD) return p;
    a = ky * ky - kx * kx;
    b = 2 * kx * ky;
    if (op == OP_FWD) begin
      nre = x * a - y * b;
      nim = x * b + y * a;
    end else begin
      nre = x * a + y * b;
      nim = y * a - x * b;
    end
    p.re = round_saturate(nre, s);
    p.im = round_saturate(nim, s);
    return p;
  endfunction

  // Send one bin; waits for acceptance.
  task automatic send_bin(logic [1:0] op, logic [7:0] row, logic [7:0] col,
                          logic signed [31:0] xr, logic signed [31:0] xi);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    row_i       <= row;
    col_i       <= col;
    sample_re_i <= xr;
    sample_im_i <= xi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_products.insert(expected_products.size(), kernel_product(op, row, col, xr, xi));
    beats_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Wait until every expected product has come back.
  task automatic drain_products();
    in_valid_i <= 1'b0;
    while (expected_products.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  // Write the grid side while idle.
  task automatic write_side(logic [8:0] value);
    drain_products();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    side_reg = value;
  endtask

  function automatic logic signed [31:0] random_sample();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'($urandom_range(0, 65535)) - 32'sd32768;
      default: return 32'($urandom());
    endcase
  endfunction

  // Extremes of the fields, every operation, zero frequency and code three.
  task automatic test_directed();
    logic [1:0] op;
    for (int i = 0; i < 4; i++) begin
      op = 2'(i);
      send_bin(op, 8'd0, 8'd0, 32'sh7FFF_FFFF, 32'sh8000_0000);
      send_bin(op, 8'd255, 8'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_bin(op, 8'd128, 8'd128, 32'sh8000_0000, 32'sh8000_0000);
      send_bin(op, 8'd3, 8'd200, 32'sh0001_0000, -32'sh0001_0000);
    end
    send_bin(OP_FWD, 8'd129, 8'd0, 32'sh0001_8000, 32'sd0);
    send_bin(OP_INV, 8'd0, 8'd127, 32'sd1, 32'sd1);
    send_bin(OP_ADJ, 8'd255, 8'd255, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  // Random bins; indices up to 255, beyond the grid side, are included.
  task automatic test_random(int count);
    int  lim;
    lim = (side_reg > 9'd256 || side_reg < 9'd2) ? 255 : int'(side_reg) - 1;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_products();
      send_bin(($urandom_range(0, 9) == 0) ? OP_RSVD : 2'($urandom_range(0, 2)),
               8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, lim)),
               8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, lim)),
               random_sample(), random_sample());
    end
  endtask

  // Receiver stall pattern: phases of none, light and heavy stalling.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Output checker and watchdog.
  always @(posedge clk_i) begin
    product_t want;
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
    if (out_valid_o && !out_stall_i) begin
      if (expected_products.size() == 0) begin
        $error("result_re: unexpected beat, actual %0d", result_re_o);
        error_count++;
      end else begin
        want = expected_products.pop_front();
        if (result_re_o !== want.re) begin
          $error("result_re: expected %0d actual %0d", want.re, result_re_o);
          error_count++;
        end
        if (result_im_o !== want.im) begin
          $error("result_im: expected %0d actual %0d", want.im, result_im_o);
          error_count++;
        end
        beats_checked++;
      end
    end
  end

  // Test sequence.
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(200);
    write_side(9'd2);
    test_directed();
    test_random(60);
    write_side(9'd17);
    test_random(100);
    write_side(9'd0);
    test_random(40);
    write_side(9'd511);
    test_random(40);
    write_side(9'd64);
    test_random(100);
    write_side(9'd256);
    test_random(60);
    drain_products();
    $display("Sent %0d bins over grid sides 2 to 256 and beyond, checked %0d results.",
             beats_sent, beats_checked);
    $display("All operations, zero frequency, code three and saturation were exercised.");
    if (error_count == 0 && expected_products.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/kskm_pkg.sv
sv/kskm_div_cell.sv
sv/kaiser_squires_kernel_multiply_top.sv
tb/sv/testbench.sv
